FILE: rtl/core/cse_pkg.sv
// shared constants, state encoding and gap shrink helper for the comb sort engine
package cse_pkg;

  // capacity of the key store and stored key width
  localparam int MAX_ELEMENTS = 64;
  localparam int KEY_WIDTH    = 32;

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

  // gap shrink: floor(gap * 10 / 13) as a multiply by a scaled reciprocal of 13
  localparam int SHRINK_NUM   = 10;
  localparam int RECIP_SHIFT  = 16;
  localparam int SHRINK_RECIP = 5042;
  localparam int PROD_W       = CNT_W + 4;
  localparam int SCALED_W     = PROD_W + 14;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_PAIR_WR,
    ST_EMIT_RD,
    ST_EMIT_SHOW
  } state_t;

  // next gap of the sort, never below one
  function automatic logic [CNT_W-1:0] shrink_gap(input logic [CNT_W-1:0] gap);
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [CNT_W-1:0]    quo;
    prod   = PROD_W'(gap) * PROD_W'(SHRINK_NUM);
    scaled = SCALED_W'(prod) * SCALED_W'(SHRINK_RECIP);
    quo    = CNT_W'(scaled >> RECIP_SHIFT);
    if (quo == '0) begin
      quo = CNT_W'(1);
    end
    return quo;
  endfunction

endpackage

FILE: rtl/core/comb_sort_engine.sv
// comb sort engine: collects a set of keys, sorts it in place and streams it out ascending
//
// Keys arrive one word per accepted input into a 64-entry key store until a
// word marked last_in closes the set; words that arrive while the store is full
// are dropped and flag overflow on every output word of that set, though a
// dropped word marked last still closes the set. The set is then sorted
// unsigned ascending by comb sort: the gap starts at the key count and shrinks
// before each pass to floor(gap*10/13), at least 1, and passes repeat while a
// pass swapped or the gap exceeds 1. All compare-swaps go through one comparator
// and the single write port of the key store: a pair takes a read and a compare
// step, plus a write step for the upper slot when it swaps, and each pass adds a
// gap update and the closing index check. A set of N keys needs about
// log(N)/log(1.3) + a few passes. The sorted keys then leave one at a time,
// each read from the store into the output register and held until taken, the
// final one carrying last_out. in_stall stays high from the closing word until
// the last sorted word has been taken; a new set starts right after that.
module comb_sort_engine (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] key_in,
  input  logic        last_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] key_out,
  output logic        last_out,
  output logic        overflow
);

  localparam int AW = cse_pkg::ADDR_W;
  localparam int CW = cse_pkg::CNT_W;
  localparam int KW = cse_pkg::KEY_WIDTH;

  // sequencer state and control registers
  cse_pkg::state_t state, state_next;
  logic [CW-1:0] element_count, element_count_next;
  logic [CW-1:0] current_gap, current_gap_next;
  logic          swap_seen, swap_seen_next;
  logic          dropped_flag, dropped_flag_next;
  logic [AW-1:0] pair_idx, pair_idx_next;     // lower index of the pair under test
  logic [AW-1:0] emit_idx, emit_idx_next;     // next sorted key to send

  // key store and its ports
  logic [KW-1:0] key_store [cse_pkg::MAX_ELEMENTS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [KW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [AW-1:0] mem_rb;
  logic [KW-1:0] rd_a;
  logic [KW-1:0] rd_b;

  logic          in_fire;
  logic          out_fire;
  logic          store_full;
  logic [CW:0]   pair_hi;                     // upper index of the pair, may pass the count
  logic [AW-1:0] hi_addr;

  assign in_stall  = (state != cse_pkg::ST_LOAD);
  assign out_valid = (state == cse_pkg::ST_EMIT_SHOW);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  assign store_full = (element_count == CW'(cse_pkg::MAX_ELEMENTS));
  assign pair_hi    = (CW + 1)'(pair_idx) + (CW + 1)'(current_gap);
  assign hi_addr    = pair_hi[AW-1:0];

  // output word comes straight from the registered store read
  assign key_out  = 32'(rd_a);
  assign last_out = ((CW'(emit_idx) + CW'(1)) == element_count);
  assign overflow = dropped_flag;

  // key store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_store[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_a <= key_store[mem_ra];
      rd_b <= key_store[mem_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cse_pkg::ST_LOAD;
      element_count <= '0;
      current_gap   <= '0;
      swap_seen     <= 1'b0;
      dropped_flag  <= 1'b0;
      pair_idx      <= '0;
      emit_idx      <= '0;
    end else begin
      state         <= state_next;
      element_count <= element_count_next;
      current_gap   <= current_gap_next;
      swap_seen     <= swap_seen_next;
      dropped_flag  <= dropped_flag_next;
      pair_idx      <= pair_idx_next;
      emit_idx      <= emit_idx_next;
    end
  end

  always_comb begin
    state_next         = state;
    element_count_next = element_count;
    current_gap_next   = current_gap;
    swap_seen_next     = swap_seen;
    dropped_flag_next  = dropped_flag;
    pair_idx_next      = pair_idx;
    emit_idx_next      = emit_idx;
    mem_we             = 1'b0;
    mem_wa             = pair_idx;
    mem_wd             = rd_b;
    mem_re             = 1'b0;
    mem_ra             = pair_idx;
    mem_rb             = hi_addr;

    case (state)
      cse_pkg::ST_LOAD: begin
        if (in_fire) begin
          // store the word unless the set is already full
          if (!store_full) begin
            mem_we             = 1'b1;
            mem_wa             = element_count[AW-1:0];
            mem_wd             = KW'(key_in);
            element_count_next = element_count + CW'(1);
          end else begin
            dropped_flag_next = 1'b1;
          end
          if (last_in) begin
            // gap starts at the key count of the closed set
            current_gap_next = store_full ? element_count : element_count + CW'(1);
            state_next       = cse_pkg::ST_PASS;
          end
        end
      end

      cse_pkg::ST_PASS: begin
        // shrink the gap and start a fresh pass
        current_gap_next = cse_pkg::shrink_gap(current_gap);
        swap_seen_next   = 1'b0;
        pair_idx_next    = '0;
        state_next       = cse_pkg::ST_PAIR_RD;
      end

      cse_pkg::ST_PAIR_RD: begin
        if (pair_hi < (CW + 1)'(element_count)) begin
          mem_re     = 1'b1;
          state_next = cse_pkg::ST_PAIR_CMP;
        end else if (swap_seen || current_gap > CW'(1)) begin
          state_next = cse_pkg::ST_PASS;
        end else begin
          emit_idx_next = '0;
          state_next    = cse_pkg::ST_EMIT_RD;
        end
      end

      cse_pkg::ST_PAIR_CMP: begin
        if (rd_a > rd_b) begin
          // lower slot gets the smaller key now, upper slot next cycle
          mem_we         = 1'b1;
          mem_wa         = pair_idx;
          mem_wd         = rd_b;
          swap_seen_next = 1'b1;
          state_next     = cse_pkg::ST_PAIR_WR;
        end else begin
          pair_idx_next = pair_idx + AW'(1);
          state_next    = cse_pkg::ST_PAIR_RD;
        end
      end

      cse_pkg::ST_PAIR_WR: begin
        mem_we        = 1'b1;
        mem_wa        = hi_addr;
        mem_wd        = rd_a;
        pair_idx_next = pair_idx + AW'(1);
        state_next    = cse_pkg::ST_PAIR_RD;
      end

      cse_pkg::ST_EMIT_RD: begin
        mem_re     = 1'b1;
        mem_ra     = emit_idx;
        state_next = cse_pkg::ST_EMIT_SHOW;
      end

      cse_pkg::ST_EMIT_SHOW: begin
        if (out_fire) begin
          if (last_out) begin
            // run done, clear for the next set
            element_count_next = '0;
            current_gap_next   = '0;
            swap_seen_next     = 1'b0;
            dropped_flag_next  = 1'b0;
            emit_idx_next      = '0;
            state_next         = cse_pkg::ST_LOAD;
          end else begin
            emit_idx_next = emit_idx + AW'(1);
            state_next    = cse_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = cse_pkg::ST_LOAD;
      end
    endcase
  end

endmodule
